>>> design/min_max_priority_queue_assert.svh
// assertion macros used by the priority queue checker
`ifndef MIN_MAX_PRIORITY_QUEUE_ASSERT_SVH
`define MIN_MAX_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, skipped while in reset
`define MMPQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mmpq assertion failed");

// next-cycle implication, skipped while in reset
`define MMPQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mmpq assertion failed");

`endif

>>> design/mmpq_pkg.sv
// types and codes shared by the min/max priority queue modules
package mmpq_pkg;

    typedef enum logic [1:0] {
        OP_INSERT     = 2'd0,
        OP_REMOVE_MIN = 2'd1,
        OP_REMOVE_MAX = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        STAT_INSERTED  = 2'd0,
        STAT_REMOVED   = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_OVERFLOW  = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic insert;      // sorted insert of the new value this cycle
        logic remove_min;  // whole row shifts one place toward cell 0
        logic occupied;    // cell index below the entry count
        logic at_end;      // cell index equals the entry count
    } cell_ctl_t;

endpackage

>>> design/min_max_priority_queue.sv
// top level of the min/max priority queue built from a sorted cell chain
//
// Usage: a command is transferred at a rising edge where start is high and
// busy is low. operation selects insert (value is stored), remove minimum or
// remove maximum. Each command gives exactly one result: done pulses high for
// one cycle with result_value and status. status reports inserted, removed,
// underflow (queue empty) or overflow (queue full or unused operation code);
// result_value is zero except for a successful removal.
// done is registered from the execute state that the transfer leads to. A new
// command is taken only while busy is low; busy is high for the one cycle in
// which the cell row executes the command. The row keeps values sorted with
// the minimum in cell 0: an insert compares the new value in every cell at
// once and shifts the larger entries right, a minimum removal shifts the whole
// row left, a maximum removal takes the last occupied cell.
// Reset clears the entry count and the control state; cell contents are not
// cleared and are never read before being written.
// The receiver cannot stall: done is a single-cycle strobe and results are
// never held back.
module min_max_priority_queue #(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   operation,
    input  logic signed [DATA_WIDTH-1:0] value,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] result_value,
    output logic [1:0]                   status
);
    import mmpq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    state_t                       state_reg, state_next;
    logic [1:0]                   op_reg;
    logic signed [DATA_WIDTH-1:0] val_reg;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic                         done_reg, done_next;
    logic signed [DATA_WIDTH-1:0] result_value_reg, result_value_next;
    logic [1:0]                   status_reg, status_next;

    logic                         accept;
    logic                         do_insert;
    logic                         do_remove_min;
    logic signed [DATA_WIDTH-1:0] cell_value [CAPACITY];
    logic                         cell_gt    [CAPACITY];
    cell_ctl_t                    cell_ctl   [CAPACITY];
    logic signed [DATA_WIDTH-1:0] last_value;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg == S_EXEC);

    // command capture on transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= operation;
            val_reg <= value;
        end
    end

    // row operations enabled only when they succeed
    assign do_insert     = (state_reg == S_EXEC) && (op_t'(op_reg) == OP_INSERT)
                           && (count_reg != CNT_W'(CAPACITY));
    assign do_remove_min = (state_reg == S_EXEC) && (op_t'(op_reg) == OP_REMOVE_MIN)
                           && (count_reg != '0);

    // cell row
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        assign cell_ctl[i].insert     = do_insert;
        assign cell_ctl[i].remove_min = do_remove_min;
        assign cell_ctl[i].occupied   = (CNT_W'(i) < count_reg);
        assign cell_ctl[i].at_end     = (CNT_W'(i) == count_reg);

        mmpq_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .clk        (clk),
            .ctl        (cell_ctl[i]),
            .new_value  (val_reg),
            .left_value ((i == 0) ? val_reg : cell_value[(i == 0) ? 0 : i - 1]),
            .left_gt    ((i == 0) ? 1'b0 : cell_gt[(i == 0) ? 0 : i - 1]),
            .right_value((i == CAPACITY - 1) ? cell_value[i]
                                             : cell_value[(i == CAPACITY - 1) ? i : i + 1]),
            .cell_value (cell_value[i]),
            .gt         (cell_gt[i])
        );
    end

    // last occupied cell holds the maximum
    always_comb
    begin
        last_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (count_reg == CNT_W'(i + 1))
            begin
                last_value = last_value | cell_value[i];
            end
        end
    end

    // sequencer next state and result
    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        done_next         = 1'b0;
        result_value_next = result_value_reg;
        status_next       = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next        = S_IDLE;
                done_next         = 1'b1;
                result_value_next = '0;
                case (op_t'(op_reg))
                    OP_INSERT:
                    begin
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            status_next = STAT_OVERFLOW;
                        end
                        else
                        begin
                            status_next = STAT_INSERTED;
                            count_next  = count_reg + 1'b1;
                        end
                    end
                    OP_REMOVE_MIN, OP_REMOVE_MAX:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STAT_UNDERFLOW;
                        end
                        else
                        begin
                            status_next       = STAT_REMOVED;
                            count_next        = count_reg - 1'b1;
                            result_value_next = (op_t'(op_reg) == OP_REMOVE_MIN)
                                                ? cell_value[0] : last_value;
                        end
                    end
                    default:
                    begin
                        status_next = STAT_OVERFLOW;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        result_value_reg <= result_value_next;
        status_reg       <= status_next;
    end

    assign done         = done_reg;
    assign result_value = result_value_reg;
    assign status       = status_reg;

endmodule

>>> design/mmpq_cell.sv
// one cell of the sorted value chain
module mmpq_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  mmpq_pkg::cell_ctl_t          ctl,
    input  logic signed [DATA_WIDTH-1:0] new_value,
    input  logic signed [DATA_WIDTH-1:0] left_value,
    input  logic                         left_gt,
    input  logic signed [DATA_WIDTH-1:0] right_value,
    output logic signed [DATA_WIDTH-1:0] cell_value,
    output logic                         gt
);
    import mmpq_pkg::*;

    logic signed [DATA_WIDTH-1:0] value_reg;
    logic signed [DATA_WIDTH-1:0] value_next;

    // this entry is larger than the incoming value
    assign gt         = ctl.occupied && (value_reg > new_value);
    assign cell_value = value_reg;

    // take the left neighbor while shifting right, the new value at the insert point
    always_comb
    begin
        value_next = value_reg;
        if (ctl.insert && (gt || ctl.at_end))
        begin
            value_next = left_gt ? left_value : new_value;
        end
        else if (ctl.remove_min)
        begin
            value_next = right_value;
        end
    end

    // entry storage, meaningful only below the entry count
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

>>> design/mmpq_checker.sv
// port-level checker for the min/max priority queue, bound to the top level
module mmpq_checker #(
    parameter int DATA_WIDTH = 32
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic signed [DATA_WIDTH-1:0] result_value,
    input logic [1:0]                   status
);
    import mmpq_pkg::*;

    `include "min_max_priority_queue_assert.svh"

    logic cmd_xfer;
    assign cmd_xfer = start && !busy;

    // a transfer always occupies the block for the next cycle
    `MMPQ_ASSERT_NXT(a_xfer_busy, clk, rst_n, cmd_xfer, busy)
    // a result follows every transfer, registered from the execute cycle
    `MMPQ_ASSERT_IMP(a_xfer_done, clk, rst_n, cmd_xfer, (##2 done))
    // the execute cycle never repeats
    `MMPQ_ASSERT_NXT(a_busy_once, clk, rst_n, busy, !busy)
    // only a successful removal carries a value
    `MMPQ_ASSERT_IMP(a_zero_value, clk, rst_n, done && (status != STAT_REMOVED), result_value == '0)

endmodule

bind min_max_priority_queue mmpq_checker #(
    .DATA_WIDTH(DATA_WIDTH)
) u_mmpq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .result_value(result_value),
    .status      (status)
);

>>> bench/tb_top.sv
// self-checking testbench for the min/max priority queue with a small scoreboard
module tb_top;
    import mmpq_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int DATA_WIDTH   = 32;
    localparam int RANDOM_ITEMS = 750;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;

    // operation code with no member in op_t, refused by the block
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // stimulus phases of the random part
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } mix_t;

    typedef struct {
        logic signed [DATA_WIDTH-1:0] value;
        status_t                      status;
    } queue_outcome_t;

    // predicts each outcome from an arrival-ordered copy of the stored values
    class queue_scoreboard;
        logic signed [DATA_WIDTH-1:0] held_values[$];
        queue_outcome_t               awaited_outcomes[$];
        int                           mismatches;

        function new();
            mismatches = 0;
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        function int pending();
            return awaited_outcomes.size();
        endfunction

        // work out the outcome of one transferred command
        function void note_transfer(logic [1:0] op, logic signed [DATA_WIDTH-1:0] val);
            queue_outcome_t outcome;
            int             pick;
            outcome.value  = '0;
            outcome.status = STAT_OVERFLOW;
            case (op)
                OP_INSERT:
                begin
                    if (held_values.size() < CAPACITY)
                    begin
                        held_values.push_back(val);
                        outcome.status = STAT_INSERTED;
                    end
                end
                OP_REMOVE_MIN, OP_REMOVE_MAX:
                begin
                    if (held_values.size() == 0)
                    begin
                        outcome.status = STAT_UNDERFLOW;
                    end
                    else
                    begin
                        // earliest arrival wins among equal extremes
                        pick = 0;
                        for (int i = 1; i < held_values.size(); i++)
                        begin
                            if (op == OP_REMOVE_MIN ? held_values[i] < held_values[pick]
                                                    : held_values[i] > held_values[pick])
                                pick = i;
                        end
                        outcome.value  = held_values[pick];
                        outcome.status = STAT_REMOVED;
                        held_values.delete(pick);
                    end
                end
                default:
                begin
                    outcome.status = STAT_OVERFLOW;
                end
            endcase
            awaited_outcomes.push_back(outcome);
        endfunction

        // compare one result with the oldest awaited outcome
        task check_result(logic signed [DATA_WIDTH-1:0] got_value, logic [1:0] got_status);
            queue_outcome_t oldest;
            if (awaited_outcomes.size() == 0)
            begin
                report($sformatf("result %0d status %0d with no command waiting",
                                 got_value, got_status));
            end
            else
            begin
                oldest = awaited_outcomes.pop_front();
                if (got_status !== oldest.status)
                    report($sformatf("status %0d, predicted %0d", got_status, oldest.status));
                if (got_value !== oldest.value)
                    report($sformatf("result_value %0d, predicted %0d",
                                     got_value, oldest.value));
            end
        endtask
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [1:0]                   operation;
    logic signed [DATA_WIDTH-1:0] value;
    logic                         done;
    logic signed [DATA_WIDTH-1:0] result_value;
    logic [1:0]                   status;

    queue_scoreboard sb;
    int              cycles;
    bit              quiet;

    min_max_priority_queue #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .value        (value),
        .done         (done),
        .result_value (result_value),
        .status       (status)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result_value, status);
    end

    // drive one command and wait for its transfer
    task send_cmd(input logic [1:0] op, input logic signed [DATA_WIDTH-1:0] val);
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < 33)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start     <= 1'b1;
        operation <= op;
        value     <= val;
        do
            @(posedge clk);
        while (busy);
        sb.note_transfer(op, val);
    endtask

    // random value with a bias toward duplicates and extremes
    function logic signed [DATA_WIDTH-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return $urandom;
        else if (roll < 70)
            return $signed($urandom_range(0, 7)) - 4;
        else if (roll < 85)
            return ($urandom_range(0, 1) == 0) ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                               : {1'b0, {(DATA_WIDTH-1){1'b1}}};
        else
            return {$urandom_range(0, 1) == 0 ? 2'b10 : 2'b01, 30'(32'($urandom_range(0, 3)))};
    endfunction

    // random operation under the current phase
    function logic [1:0] pick_op(mix_t mix);
        int roll;
        int insert_share;
        roll = $urandom_range(0, 99);
        insert_share = (mix == MIX_FILL) ? 85 : (mix == MIX_DRAIN) ? 20 : 50;
        if (roll < 3)
            return OP_UNUSED;
        else if (roll < insert_share)
            return OP_INSERT;
        else if ($urandom_range(0, 1) == 0)
            return OP_REMOVE_MIN;
        else
            return OP_REMOVE_MAX;
    endfunction

    initial
    begin
        mix_t mix;
        sb        = new();
        cycles    = 0;
        quiet     = 1'b0;
        rst_n     = 1'b0;
        start     = 1'b0;
        operation = OP_INSERT;
        value     = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty removals, unused code, extremes, equal values
        send_cmd(OP_REMOVE_MIN, 32'sd0);
        send_cmd(OP_REMOVE_MAX, -32'sd1);
        send_cmd(OP_UNUSED, 32'sd17);
        send_cmd(OP_INSERT, 32'h7fffffff);
        send_cmd(OP_INSERT, 32'h80000000);
        send_cmd(OP_INSERT, 32'sd0);
        send_cmd(OP_INSERT, -32'sd1);
        send_cmd(OP_INSERT, 32'sd5);
        send_cmd(OP_INSERT, 32'sd5);
        send_cmd(OP_INSERT, 32'sd5);
        send_cmd(OP_UNUSED, 32'h7fffffff);
        send_cmd(OP_REMOVE_MAX, 32'sd0);
        send_cmd(OP_REMOVE_MIN, 32'sd0);
        send_cmd(OP_REMOVE_MIN, 32'sd0);
        send_cmd(OP_REMOVE_MAX, 32'sd0);
        send_cmd(OP_REMOVE_MIN, 32'sd0);
        send_cmd(OP_REMOVE_MAX, 32'sd0);
        send_cmd(OP_REMOVE_MIN, 32'sd0);
        send_cmd(OP_REMOVE_MAX, 32'sd0);
        send_cmd(OP_REMOVE_MIN, 32'sd0);

        // random part in fill, drain and even phases
        mix = MIX_FILL;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
                mix = mix_t'($urandom_range(0, 2));
            quiet = (n >= 300 && n < 450);
            send_cmd(pick_op(mix), pick_value());
        end
        quiet = 1'b0;

        // wait out the last results
        @(negedge clk);
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/mmpq_pkg.sv
design/mmpq_cell.sv
design/min_max_priority_queue.sv
design/mmpq_checker.sv
bench/tb_top.sv
